// ===== src/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants for the Bayer demosaic block
// Field widths, register map, reset values and the site classification.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // fixed field widths
  localparam int RAW_W    = 10;
  localparam int COLOR_W  = 10;
  localparam int POS_W    = 12;
  localparam int DIM_W    = 13;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // dimension limits applied when the registers are used
  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd3;
  localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // color arrangement around the window center
  typedef enum logic [1:0] {
    SITE_BLUE    = 2'b00,
    SITE_RED     = 2'b01,
    SITE_GREEN_B = 2'b10,  // green on a blue row
    SITE_GREEN_R = 2'b11   // green on a red row
  } site_t;

  typedef struct packed {
    logic              emit;
    site_t             site;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              last;
  } meta_t;

endpackage

// ===== src/bbd_if.sv =====
// ----------------------------------------------------------------------------
// bbd_if: stream channels of the demosaic block
// Raw sample channel and RGB result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbd_in_if import bbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  logic             frame_start;

  modport source (output valid, raw_sample, frame_start, input ready);
  modport sink   (input valid, raw_sample, frame_start, output ready);
endinterface

interface bbd_out_if import bbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [POS_W-1:0]   pixel_column;
  logic [POS_W-1:0]   pixel_row;
  logic               frame_last;

  modport source (output valid, red, green, blue, pixel_column, pixel_row, frame_last,
                  input ready);
  modport sink   (input valid, red, green, blue, pixel_column, pixel_row, frame_last,
                  output ready);
endinterface

// ===== src/bayer_bilinear_demosaic_unit.sv =====
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit: bilinear demosaic of a BGGR raw stream
// Two line stores feed a 3x3 window; one RGB word per interior pixel.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in_word   sink       valid/ready             raw_sample, frame_start
//   out_word  source     valid/ready             red, green, blue,
//                                                pixel_column, pixel_row,
//                                                frame_last
//   cfg (APB) slave      psel/penable, pready=1  0x0 frame_width,
//                                                0x4 frame_height
//
// One raw word per clock, sustained until back-pressure fills the queue. An
// accepted word is registered in the front stage (line-store read/write),
// passes the 4-entry queue and is turned into a result in the back stage,
// whose output register drives out_word.valid. The single-ported line-store
// banks set the pace at one access per word.
// rst_n is synchronous, active low; the line stores are not cleared, since
// words read before the raster writes them leave the window before any
// result uses them.
// Back-pressure on out_word fills the queue first; in_word.ready drops only
// when the queue and the front stage are both full. Border words produce no
// result and never stall the output side.
//
module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bbd_in_if.sink                in_word,
  bbd_out_if.source             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // stored sample width; inputs are 10 bits, anything above is zero
  localparam int SBITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam int REC_W = 3 * SBITS + $bits(meta_t);

  // ---- configuration registers ----
  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic             cfg_write;
  logic             cfg_reg_sel;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign cfg_reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_sel)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_sel)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // ---- front: position, line stores, classification ----
  logic             fq_valid, fq_ready;
  logic [REC_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [REC_W-1:0] qb_data;

  bbd_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SBITS       (SBITS),
    .REC_W       (REC_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_word      (in_word),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .push_valid   (fq_valid),
    .push_ready   (fq_ready),
    .push_data    (fq_data)
  );

  // ---- decoupling queue ----
  bbd_queue #(
    .DATA_W (REC_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // ---- back: window and interpolation, output register ----
  bbd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SBITS       (SBITS),
    .REC_W       (REC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data),
    .out_word  (out_word)
  );

endmodule

// ===== src/bbd_front.sv =====
// ----------------------------------------------------------------------------
// bbd_front: raster position tracking, line stores and site classification
// Accepts raw words, reads/writes the two line stores and emits one record.
// ----------------------------------------------------------------------------
module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 10,
  parameter int SBITS       = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W,
  parameter int REC_W       = 3 * SBITS + $bits(meta_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  bbd_in_if.sink           in_word,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [REC_W-1:0] push_data
);

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int MW_B  = $clog2(MAX_WIDTH + 1);
  localparam int WB    = (MW_B > DIM_W) ? MW_B : DIM_W;

  // line stores, one per row parity
  logic [SBITS-1:0] mem0 [MAX_WIDTH];
  logic [SBITS-1:0] mem1 [MAX_WIDTH];
  logic [SBITS-1:0] rd0_r, rd1_r;

  logic [CB-1:0]    col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic [SBITS-1:0] s1_sample_r;
  logic             s1_bank_r;
  meta_t            s1_meta_r;

  logic             accept;
  logic [WB-1:0]    w_cfg, w_eff, c_ext, c_inc;
  logic [DIM_W-1:0] h_eff, r_ext, r_inc;
  logic [CB-1:0]    c_cur;
  logic [POS_W-1:0] r_cur;
  logic [SBITS-1:0] sample;
  logic [POS_W-1:0] x_pos, y_pos;
  meta_t            meta;
  logic [SBITS-1:0] top, mid;

  assign in_word.ready = !s1_valid_r || push_ready;
  assign accept        = in_word.valid && in_word.ready;
  assign sample        = in_word.raw_sample[SBITS-1:0];

  // clamp the frame size registers
  always_comb begin
    w_cfg = WB'(frame_width);
    if (w_cfg < WB'(DIM_MIN)) begin
      w_eff = WB'(DIM_MIN);
    end else if (w_cfg > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (frame_height < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (frame_height > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = frame_height;
    end
  end

  // position and classification of the word at hand
  always_comb begin
    c_cur = in_word.frame_start ? '0 : col_r;
    r_cur = in_word.frame_start ? '0 : row_r;
    c_ext = WB'(c_cur);
    r_ext = DIM_W'(r_cur);
    x_pos = POS_W'(c_ext - WB'(1));
    y_pos = r_cur - POS_W'(1);

    meta.emit = (c_ext >= WB'(2)) && (c_ext < w_eff) &&
                (r_ext >= DIM_W'(2)) && (r_ext < h_eff);
    meta.col  = x_pos;
    meta.row  = y_pos;
    meta.last = (c_ext == w_eff - WB'(1)) && (r_ext == h_eff - DIM_W'(1));
    case ({x_pos[0], y_pos[0]})
      2'b00:   meta.site = SITE_BLUE;
      2'b11:   meta.site = SITE_RED;
      2'b10:   meta.site = SITE_GREEN_B;
      2'b01:   meta.site = SITE_GREEN_R;
      default: meta.site = SITE_BLUE;
    endcase

    c_inc = c_ext + WB'(1);
    r_inc = r_ext + DIM_W'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[POS_W-1:0];
    end else begin
      col_nxt = c_inc[CB-1:0];
      row_nxt = r_cur;
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // read old contents, then overwrite the bank of this row's parity
  always_ff @(posedge clk) begin
    if (accept) begin
      rd0_r <= mem0[c_cur];
      rd1_r <= mem1[c_cur];
      if (r_cur[0]) begin
        mem1[c_cur] <= sample;
      end else begin
        mem0[c_cur] <= sample;
      end
      s1_sample_r <= sample;
      s1_bank_r   <= r_cur[0];
      s1_meta_r   <= meta;
    end
  end

  assign top        = s1_bank_r ? rd1_r : rd0_r;
  assign mid        = s1_bank_r ? rd0_r : rd1_r;
  assign push_valid = s1_valid_r;
  assign push_data  = {top, mid, s1_sample_r, s1_meta_r};

endmodule

// ===== src/bbd_queue.sv =====
// ----------------------------------------------------------------------------
// bbd_queue: short FIFO between front and back
// Four entries, full rate with simultaneous push and pop while not full.
// ----------------------------------------------------------------------------
module bbd_queue import bbd_pkg::*; #(
  parameter int DATA_W = 58
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/bbd_back.sv =====
// ----------------------------------------------------------------------------
// bbd_back: 3x3 window and bilinear interpolation
// Shifts each record into the window and registers the RGB result.
// ----------------------------------------------------------------------------
module bbd_back import bbd_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int SBITS       = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W,
  parameter int REC_W       = 3 * SBITS + $bits(meta_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [REC_W-1:0] pop_data,
  bbd_out_if.source        out_word
);

  logic [SBITS-1:0] win_r [3][3];
  logic [SBITS-1:0] win_nxt [3][3];

  logic [SBITS-1:0] top, mid, sample;
  meta_t            meta;
  logic             pop;

  logic [SBITS+1:0] edge_sum, diag_sum;
  logic [SBITS:0]   hsum, vsum;
  logic [SBITS-1:0] edge_avg, diag_avg, hav, vav, here;
  logic [SBITS-1:0] red_c, green_c, blue_c;

  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic [POS_W-1:0]   col_r, row_r;
  logic               last_r;

  assign {top, mid, sample, meta} = pop_data;

  assign pop_ready = !out_valid_r || out_word.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = sample;
  end

  always_comb begin
    edge_sum = (SBITS+2)'(win_nxt[0][1]) + (SBITS+2)'(win_nxt[2][1]) +
               (SBITS+2)'(win_nxt[1][0]) + (SBITS+2)'(win_nxt[1][2]);
    diag_sum = (SBITS+2)'(win_nxt[0][0]) + (SBITS+2)'(win_nxt[0][2]) +
               (SBITS+2)'(win_nxt[2][0]) + (SBITS+2)'(win_nxt[2][2]);
    hsum     = (SBITS+1)'(win_nxt[1][0]) + (SBITS+1)'(win_nxt[1][2]);
    vsum     = (SBITS+1)'(win_nxt[0][1]) + (SBITS+1)'(win_nxt[2][1]);
    edge_avg = edge_sum[SBITS+1:2];
    diag_avg = diag_sum[SBITS+1:2];
    hav      = hsum[SBITS:1];
    vav      = vsum[SBITS:1];
    here     = win_nxt[1][1];

    case (meta.site)
      SITE_RED: begin
        red_c = here;  green_c = edge_avg; blue_c = diag_avg;
      end
      SITE_BLUE: begin
        red_c = diag_avg; green_c = edge_avg; blue_c = here;
      end
      SITE_GREEN_B: begin
        red_c = vav; green_c = here; blue_c = hav;
      end
      SITE_GREEN_R: begin
        red_c = hav; green_c = here; blue_c = vav;
      end
      default: begin
        red_c = here; green_c = here; blue_c = here;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = meta.emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_word.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && meta.emit) begin
      red_r   <= COLOR_W'(red_c);
      green_r <= COLOR_W'(green_c);
      blue_r  <= COLOR_W'(blue_c);
      col_r   <= meta.col;
      row_r   <= meta.row;
      last_r  <= meta.last;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.red          = red_r;
  assign out_word.green        = green_r;
  assign out_word.blue         = blue_r;
  assign out_word.pixel_column = col_r;
  assign out_word.pixel_row    = row_r;
  assign out_word.frame_last   = last_r;

endmodule

// ===== test/bayer_bilinear_demosaic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_unit_tb: self-checking bench for the BGGR demosaic
// Drives raw words in raster order and programs the frame size over the
// config port. An in-bench model predicts every RGB word, and the bench
// compares each one field by field. A short table of words comes first, then
// random frames, then out-of-range frame sizes.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_unit_tb import bbd_pkg::*; ();

  localparam int          LINE_MAX    = 4096;     // line store depth per bank
  localparam int          RAND_ITEMS  = 600;      // random words before the size extremes
  localparam int          WIDE_ITEMS  = 40;       // words into the clamped-wide frame
  localparam int          TALL_ROWS   = 24;       // rows sent into the clamped-tall frame
  localparam int          LAT_TAIL    = 12;       // pipe + queue flush margin
  localparam int          DRAIN_LIMIT = 5000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               last;
  } rgb_word_t;

  typedef struct {
    logic [RAW_W-1:0] raw;
    logic             fs;
    bit               pinned;   // expected word typed in below
    rgb_word_t        want;
  } probe_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  bbd_in_if  in_if ();
  bbd_out_if out_if ();

  bayer_bilinear_demosaic_unit #(
    .MAX_WIDTH   (LINE_MAX),
    .SAMPLE_BITS (RAW_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if.sink),
    .out_word (out_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a copy of the raster position, both line banks, the 3x3
  // window and the two size registers as last written.
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0] row_mem [2][LINE_MAX];
  logic [RAW_W-1:0] tap [3][3] = '{default: '0};
  int unsigned      scan_col = 0;
  int unsigned      scan_row = 0;
  logic [DIM_W-1:0] width_shadow  = FRAME_WIDTH_RST;
  logic [DIM_W-1:0] height_shadow = FRAME_HEIGHT_RST;

  rgb_word_t   pending_rgb [$];   // RGB words still owed by the block
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // expectation typed into the table rides along with the word
  bit        pin_on;
  rgb_word_t pin_word;

  // idling switches, flipped per phase
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned stall_left  = 0;

  // registers are clamped only when used
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // one raw word in, at most one RGB word out
  function automatic void predict_rgb(input logic [RAW_W-1:0] s, input logic fs,
                                      output bit emit, output rgb_word_t px);
    int unsigned w, h, c, r, ci, bank, up2, up1, here, x, y;
    int unsigned edge_avg, diag_avg, hav, vav;
    int          i;
    site_t       site;
    emit = 1'b0;
    px   = '0;
    w = clamp_dim(width_shadow, LINE_MAX);
    h = clamp_dim(height_shadow, 32'(HEIGHT_MAX));
    if (fs) begin
      scan_col = 0;
      scan_row = 0;
    end
    c    = scan_col;
    r    = scan_row;
    ci   = c % LINE_MAX;
    bank = r & 1;
    up2  = 32'(row_mem[bank][ci]);        // row r-2
    up1  = 32'(row_mem[bank ^ 1][ci]);    // row r-1
    row_mem[bank][ci] = s;
    for (i = 0; i < 3; i++) begin
      tap[i][0] = tap[i][1];
      tap[i][1] = tap[i][2];
    end
    tap[0][2] = RAW_W'(up2);
    tap[1][2] = RAW_W'(up1);
    tap[2][2] = s;

    // the window center is one column and one row behind the raster
    if (c >= 2 && c < w && r >= 2 && r < h) begin
      x        = c - 1;
      y        = r - 1;
      here     = 32'(tap[1][1]);
      edge_avg = (tap[0][1] + tap[2][1] + tap[1][0] + tap[1][2]) / 4;
      diag_avg = (tap[0][0] + tap[0][2] + tap[2][0] + tap[2][2]) / 4;
      hav      = (tap[1][0] + tap[1][2]) / 2;
      vav      = (tap[0][1] + tap[2][1]) / 2;
      if ((x & 1) == (y & 1)) site = (x & 1) ? SITE_RED : SITE_BLUE;
      else site = (y & 1) ? SITE_GREEN_R : SITE_GREEN_B;
      case (site)
        SITE_BLUE: begin
          px.red   = COLOR_W'(diag_avg);
          px.green = COLOR_W'(edge_avg);
          px.blue  = COLOR_W'(here);
        end
        SITE_RED: begin
          px.red   = COLOR_W'(here);
          px.green = COLOR_W'(edge_avg);
          px.blue  = COLOR_W'(diag_avg);
        end
        SITE_GREEN_B: begin
          px.red   = COLOR_W'(vav);
          px.green = COLOR_W'(here);
          px.blue  = COLOR_W'(hav);
        end
        default: begin
          px.red   = COLOR_W'(hav);
          px.green = COLOR_W'(here);
          px.blue  = COLOR_W'(vav);
        end
      endcase
      px.col  = POS_W'(x);
      px.row  = POS_W'(y);
      px.last = (c == w - 1) && (r == h - 1);
      emit    = 1'b1;
    end

    // excess words wrap the column, then the row
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    scan_col = c;
    scan_row = r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
    end
  endfunction

  // mostly no pause, sometimes a few cycles, rarely a long one
  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // extremes show up more often than a flat spread would give them
  function automatic logic [RAW_W-1:0] pick_sample();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every accepted raw word, check every accepted
  // RGB word against the oldest expectation. One block so that a word taken
  // and a word delivered on the same edge are handled in a fixed order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    bit        emit;
    rgb_word_t px;
    rgb_word_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      if (rst_n && in_if.valid && in_if.ready) begin
        predict_rgb(in_if.raw_sample, in_if.frame_start, emit, px);
        if (pin_on) pending_rgb.push_back(pin_word);
        else if (emit) pending_rgb.push_back(px);
      end
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_rgb.size() == 0) begin
          fail_count++;
          $error("RGB word at column %0d row %0d with nothing expected",
                 out_if.pixel_column, out_if.pixel_row);
        end else begin
          want = pending_rgb.pop_front();
          check_field("red", 32'(want.red), 32'(out_if.red));
          check_field("green", 32'(want.green), 32'(out_if.green));
          check_field("blue", 32'(want.blue), 32'(out_if.blue));
          check_field("pixel_column", 32'(want.col), 32'(out_if.pixel_column));
          check_field("pixel_row", 32'(want.row), 32'(out_if.pixel_row));
          check_field("frame_last", 32'(want.last), 32'(out_if.frame_last));
        end
      end
    end
  end

  // result side back-pressure: ready stretches and stalls of random length
  always @(posedge clk) begin : sink_pace
    bit take;
    if (!snk_idle_on) begin
      out_if.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      take = ($urandom_range(0, 2) != 0);
      out_if.ready <= take;
      stall_left = take ? $urandom_range(0, 15) : pause_len();
    end
  end

  // one APB transfer: setup cycle, then access until pready
  task automatic cfg_access(input bit wr, input logic idx, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // program both size registers and read them back; junk fills the unused
  // upper bits of the data bus
  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input bit junk);
    logic [CFG_DATA_W-1:0] wd, rd;
    wd = junk ? (($urandom & 32'hFFFF_E000) | 32'(w)) : 32'(w);
    cfg_access(1'b1, REG_FRAME_WIDTH, wd, rd);
    width_shadow = wd[DIM_W-1:0];
    cfg_access(1'b0, REG_FRAME_WIDTH, '0, rd);
    check_field("frame_width", 32'(width_shadow), rd);
    wd = junk ? (($urandom & 32'hFFFF_E000) | 32'(h)) : 32'(h);
    cfg_access(1'b1, REG_FRAME_HEIGHT, wd, rd);
    height_shadow = wd[DIM_W-1:0];
    cfg_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
    check_field("frame_height", 32'(height_shadow), rd);
  endtask

  // present one raw word, with an optional gap first, and hold until taken
  task automatic send_raw(input logic [RAW_W-1:0] s, input logic fs, input bit pin,
                          input rgb_word_t pw);
    int unsigned gap;
    gap = src_idle_on ? pause_len() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.raw_sample  <= s;
    in_if.frame_start <= fs;
    pin_on            <= pin;
    pin_word          <= pw;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop sending until every owed RGB word is back, then let border words
  // still in the pipe drain
  task automatic wait_quiet(input int tail);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rgb.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    probe_row_t            pr;
    probe_row_t            probe_rows [$];
    logic [CFG_DATA_W-1:0] rd;
    int                    c, r, k, n, hold_at, waited;
    int unsigned           w, h, frames, random_sent, span_w;
    bit                    keep_going, first;
    logic                  fs;

    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.raw_sample  <= '0;
    in_if.frame_start <= 1'b0;
    pin_on            <= 1'b0;
    pin_word          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // size registers come up at their reset values
    cfg_access(1'b0, REG_FRAME_WIDTH, '0, rd);
    check_field("frame_width", 32'(FRAME_WIDTH_RST), rd);
    cfg_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
    check_field("frame_height", 32'(FRAME_HEIGHT_RST), rd);

    // ---- directed table on a 4x4 frame: red, blue and both green sites ----
    set_frame(13'd4, 13'd4, 1'b0);

    // a stray word, then frame_start pulls the raster back to the origin
    pr.raw = 10'h155; pr.fs = 1'b0; pr.pinned = 1'b0; pr.want = '0;
    probe_rows.push_back(pr);
    // full-scale frame: every site interpolates to full scale
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) begin
        pr.raw         = '1;
        pr.fs          = (r == 0 && c == 0);
        pr.pinned      = (c >= 2 && r >= 2);
        pr.want.red    = '1;
        pr.want.green  = '1;
        pr.want.blue   = '1;
        pr.want.col    = POS_W'(c - 1);
        pr.want.row    = POS_W'(r - 1);
        pr.want.last   = (c == 3 && r == 3);
        probe_rows.push_back(pr);
      end
    end
    // next frame starts by row wrap alone; all-zero up to the first pixel
    for (k = 0; k < 11; k++) begin
      pr.raw    = '0;
      pr.fs     = 1'b0;
      pr.pinned = (k == 10);
      pr.want   = '0;
      pr.want.col = POS_W'(1);
      pr.want.row = POS_W'(1);
      probe_rows.push_back(pr);
    end
    foreach (probe_rows[i])
      send_raw(probe_rows[i].raw, probe_rows[i].fs, probe_rows[i].pinned, probe_rows[i].want);

    // ---- random frames, mostly small ----
    // span_w: narrowest width since the last frame_start. Continuing a frame
    // without frame_start is only safe when the width does not grow, or the
    // line store would be read where it was never written.
    span_w      = 4;
    random_sent = 0;
    first       = 1'b1;
    while (random_sent < RAND_ITEMS) begin
      k = $urandom_range(0, 19);
      if (k < 14) w = $urandom_range(3, 8);
      else if (k < 19) w = $urandom_range(9, 20);
      else w = $urandom_range(21, 64);
      h = (w > 20) ? $urandom_range(3, 4) : $urandom_range(3, 8);
      wait_quiet(LAT_TAIL);
      set_frame(DIM_W'(w), DIM_W'(h), $urandom_range(0, 9) == 0);
      keep_going  = (w <= span_w) && ($urandom_range(0, 1) == 1);
      span_w      = w;
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      frames  = $urandom_range(1, 2);
      n       = frames * w * h + $urandom_range(0, w * h - 1);
      if (random_sent + n > RAND_ITEMS) n = RAND_ITEMS - int'(random_sent);
      hold_at = (first || $urandom_range(0, 2) == 0) ? n / 2 : -1;
      for (k = 0; k < n; k++) begin
        if (k == hold_at) wait_quiet(1);
        if (k == 0) fs = !keep_going;
        else if (k % (w * h) == 0) fs = ($urandom_range(0, 1) == 1);
        else fs = ($urandom_range(0, 49) == 0);   // restart mid-frame now and then
        send_raw(pick_sample(), fs, 1'b0, '0);
      end
      random_sent += n;
      first = 1'b0;
    end

    // ---- out-of-range register values, clamped when used ----
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    wait_quiet(LAT_TAIL);
    set_frame(13'd8191, 13'd0, 1'b0);       // clamps to 4096 x 3, first row only
    for (k = 0; k < WIDE_ITEMS; k++)
      send_raw(pick_sample(), k == 0, 1'b0, '0);
    wait_quiet(LAT_TAIL);
    set_frame(13'd2, 13'd0, 1'b1);          // clamps to 3 x 3, two whole frames
    for (k = 0; k < 2 * 3 * 3; k++)
      send_raw(pick_sample(), k == 0, 1'b0, '0);
    wait_quiet(LAT_TAIL);
    set_frame(13'd2, 13'd5000, 1'b1);       // clamps to 3 x 4096
    for (k = 0; k < 3 * TALL_ROWS; k++)
      send_raw(pick_sample(), k == 0, 1'b0, '0);

    // ---- wind down ----
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LAT_TAIL) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      fail_count++;
      $error("%0d RGB words never arrived", pending_rgb.size());
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
